### hdl/bfs_adjacency_matrix_walk_unit_defines.svh
// Assertion macros shared by the breadth first walk unit.
`ifndef BFS_ADJACENCY_MATRIX_WALK_UNIT_DEFINES_SVH
`define BFS_ADJACENCY_MATRIX_WALK_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define BFSAM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bfsam assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define BFSAM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bfsam assertion failed");

`endif

### hdl/bfsam_pkg.sv
// Package with the types, constants and helpers of the breadth first walk unit.
package bfsam_pkg;

   localparam int MAX_NODES = 16;
   localparam int IDX_W     = $clog2(MAX_NODES);
   localparam int CNT_W     = IDX_W + 1;
   localparam int NODE_W    = 4;
   localparam int CFG_W     = 5;

   typedef logic [MAX_NODES-1:0] row_type;
   typedef logic [IDX_W-1:0]     idx_type;
   typedef logic [CNT_W-1:0]     cnt_type;

   typedef enum logic {
      REQ_EDGE   = 1'b0,
      REQ_SEARCH = 1'b1
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_POP,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   // Bit i is set for every node i below the live node count.
   function automatic row_type live_mask(input cnt_type n);
      row_type m;
      for (int i = 0; i < MAX_NODES; i++) begin
         m[i] = (cnt_type'(i) < n);
      end
      return m;
   endfunction

endpackage

### hdl/bfsam_pick.sv
// Lowest set bit finder shared by every neighbor scan step.
module bfsam_pick (
   input  bfsam_pkg::row_type cand_i,
   output logic               found_o,
   output bfsam_pkg::idx_type index_o
);

   always_comb begin
      index_o = '0;
      for (int i = bfsam_pkg::MAX_NODES - 1; i >= 0; i--) begin
         if (cand_i[i]) begin
            index_o = bfsam_pkg::IDX_W'(i);
         end
      end
   end

   assign found_o = |cand_i;

endmodule

### hdl/bfs_adjacency_matrix_walk_unit.sv
// Breadth first walk over an adjacency bit matrix, one edge or one search per transaction.
// An edge transaction produces no result.
// A bad start gives its one result in the cycle after acceptance.
// A search fetches, pops and scans each dequeued node in turn, then flushes the held result;
// the single lowest-bit finder steps one neighbor per cycle during the scan.
// Synchronous reset clears the matrix, the sequencer and node_count to 16.
`include "bfs_adjacency_matrix_walk_unit_defines.svh"

module bfs_adjacency_matrix_walk_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_type,
   input  logic [bfsam_pkg::NODE_W-1:0]  req_node_a,
   input  logic [bfsam_pkg::NODE_W-1:0]  req_node_b,
   output logic                          rsp_strobe,
   output logic [bfsam_pkg::NODE_W-1:0]  rsp_visited_node,
   output logic                          rsp_last_of_run,
   output logic                          rsp_bad_start,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bfsam_pkg::CFG_W-1:0]   csr_data
);

   bfsam_pkg::state_type state_ff, state_in;
   bfsam_pkg::row_type   rows_ff [bfsam_pkg::MAX_NODES];
   bfsam_pkg::row_type   rows_in [bfsam_pkg::MAX_NODES];
   bfsam_pkg::row_type   visited_ff, visited_in;
   bfsam_pkg::row_type   cand_ff, cand_in;
   bfsam_pkg::cnt_type   head_ff, head_in;
   bfsam_pkg::cnt_type   tail_ff, tail_in;
   bfsam_pkg::idx_type   pend_ff, pend_in;
   bfsam_pkg::idx_type   q_rd_ff;
   logic [bfsam_pkg::CFG_W-1:0]  node_count_ff;
   logic                         rsp_strobe_ff, rsp_strobe_in;
   logic [bfsam_pkg::NODE_W-1:0] rsp_node_ff, rsp_node_in;
   logic                         rsp_last_ff, rsp_last_in;
   logic                         rsp_bad_ff, rsp_bad_in;

   bfsam_pkg::idx_type queue_mem [bfsam_pkg::MAX_NODES];
   logic               q_we;
   bfsam_pkg::idx_type q_waddr, q_wdata;
   logic               q_re;

   bfsam_pkg::cnt_type live_cnt;
   bfsam_pkg::row_type live_bits;
   bfsam_pkg::idx_type idx_a, idx_b, pick_idx;
   logic               pick_found;
   logic               accept, a_ok, b_ok;

   bfsam_pick u_pick (
      .cand_i  (cand_ff),
      .found_o (pick_found),
      .index_o (pick_idx)
   );

   assign live_cnt = (32'(node_count_ff) > bfsam_pkg::MAX_NODES)
                     ? bfsam_pkg::CNT_W'(bfsam_pkg::MAX_NODES)
                     : bfsam_pkg::CNT_W'(node_count_ff);
   assign live_bits = bfsam_pkg::live_mask(live_cnt);
   assign idx_a     = bfsam_pkg::IDX_W'(req_node_a);
   assign idx_b     = bfsam_pkg::IDX_W'(req_node_b);
   assign a_ok      = bfsam_pkg::CNT_W'(req_node_a) < live_cnt;
   assign b_ok      = bfsam_pkg::CNT_W'(req_node_b) < live_cnt;
   assign accept    = start && !busy;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bfsam_pkg::ST_IDLE: begin
            if (accept && req_type == bfsam_pkg::REQ_SEARCH && a_ok) begin
               state_in = bfsam_pkg::ST_FETCH;
            end
         end
         bfsam_pkg::ST_FETCH: begin
            state_in = (head_ff < tail_ff) ? bfsam_pkg::ST_POP : bfsam_pkg::ST_FLUSH;
         end
         bfsam_pkg::ST_POP:   state_in = bfsam_pkg::ST_SCAN;
         bfsam_pkg::ST_SCAN: begin
            if (!pick_found) begin
               state_in = bfsam_pkg::ST_FETCH;
            end
         end
         bfsam_pkg::ST_FLUSH: state_in = bfsam_pkg::ST_IDLE;
         default:             state_in = bfsam_pkg::ST_IDLE;
      endcase
   end

   // Datapath controls and next values.
   always_comb begin
      rows_in       = rows_ff;
      visited_in    = visited_ff;
      cand_in       = cand_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      pend_in       = pend_ff;
      rsp_strobe_in = 1'b0;
      rsp_node_in   = rsp_node_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_bad_in    = rsp_bad_ff;
      q_we          = 1'b0;
      q_waddr       = bfsam_pkg::IDX_W'(tail_ff);
      q_wdata       = pick_idx;
      q_re          = 1'b0;
      case (state_ff)
         bfsam_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_type == bfsam_pkg::REQ_EDGE) begin
                  if (a_ok && b_ok) begin
                     rows_in[idx_a][idx_b] = 1'b1;
                     rows_in[idx_b][idx_a] = 1'b1;
                  end
               end else if (!a_ok) begin
                  rsp_strobe_in = 1'b1;
                  rsp_node_in   = req_node_a;
                  rsp_last_in   = 1'b1;
                  rsp_bad_in    = 1'b1;
               end else begin
                  visited_in = bfsam_pkg::row_type'(1) << idx_a;
                  head_in    = '0;
                  tail_in    = bfsam_pkg::CNT_W'(1);
                  pend_in    = idx_a;
                  q_we       = 1'b1;
                  q_waddr    = '0;
                  q_wdata    = idx_a;
               end
            end
         end
         bfsam_pkg::ST_FETCH: begin
            if (head_ff < tail_ff) begin
               q_re    = 1'b1;
               head_in = head_ff + bfsam_pkg::CNT_W'(1);
            end
         end
         bfsam_pkg::ST_POP: begin
            cand_in = rows_ff[q_rd_ff] & ~visited_ff & live_bits;
         end
         bfsam_pkg::ST_SCAN: begin
            if (pick_found) begin
               // The held result is not the last one, since another node was found.
               visited_in    = visited_ff | (bfsam_pkg::row_type'(1) << pick_idx);
               cand_in       = cand_ff & ~(bfsam_pkg::row_type'(1) << pick_idx);
               rsp_strobe_in = 1'b1;
               rsp_node_in   = bfsam_pkg::NODE_W'(pend_ff);
               rsp_last_in   = 1'b0;
               rsp_bad_in    = 1'b0;
               pend_in       = pick_idx;
               if (32'(tail_ff) < bfsam_pkg::MAX_NODES) begin
                  q_we    = 1'b1;
                  tail_in = tail_ff + bfsam_pkg::CNT_W'(1);
               end
            end
         end
         bfsam_pkg::ST_FLUSH: begin
            rsp_strobe_in = 1'b1;
            rsp_node_in   = bfsam_pkg::NODE_W'(pend_ff);
            rsp_last_in   = 1'b1;
            rsp_bad_in    = 1'b0;
         end
         default: begin
            rsp_strobe_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bfsam_pkg::ST_IDLE;
         rsp_strobe_ff <= 1'b0;
         node_count_ff <= bfsam_pkg::CFG_W'(16);
         head_ff       <= '0;
         tail_ff       <= '0;
         visited_ff    <= '0;
         for (int i = 0; i < bfsam_pkg::MAX_NODES; i++) begin
            rows_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         visited_ff    <= visited_in;
         rows_ff       <= rows_in;
         if (csr_valid && csr_ready) begin
            node_count_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cand_ff     <= cand_in;
      pend_ff     <= pend_in;
      rsp_node_ff <= rsp_node_in;
      rsp_last_ff <= rsp_last_in;
      rsp_bad_ff  <= rsp_bad_in;
   end

   // Node queue storage with a registered read port.
   always_ff @(posedge clock) begin
      if (q_we) begin
         queue_mem[q_waddr] <= q_wdata;
      end
      if (q_re) begin
         q_rd_ff <= queue_mem[bfsam_pkg::IDX_W'(head_ff)];
      end
   end

   assign busy             = (state_ff != bfsam_pkg::ST_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_visited_node = rsp_node_ff;
   assign rsp_last_of_run  = rsp_last_ff;
   assign rsp_bad_start    = rsp_bad_ff;

   `BFSAM_ASSERT_NOW(a_head_behind_tail, clock, reset, busy, head_ff <= tail_ff)
   `BFSAM_ASSERT_NOW(a_visited_matches_tail, clock, reset, busy,
                     $countones(visited_ff) == int'(tail_ff))
   `BFSAM_ASSERT_NEXT(a_scan_find_emits, clock, reset,
                      state_ff == bfsam_pkg::ST_SCAN && pick_found, rsp_strobe_ff)
   `BFSAM_ASSERT_NOW(a_bad_start_is_last, clock, reset,
                     rsp_strobe_ff && rsp_bad_ff, rsp_last_ff)

endmodule

### bench/bfs_adjacency_matrix_walk_unit_test.sv
// Self-checking testbench for the breadth first walk unit over an adjacency bit matrix.
`timescale 1ns / 100ps

module bfs_adjacency_matrix_walk_unit_test;

   typedef struct packed {
      logic [bfsam_pkg::NODE_W-1:0] node;
      logic                         last_flag;
      logic                         bad_flag;
   } walk_step_type;

   // Keeps a private copy of the matrix and node count and predicts each walk.
   class bfs_walk_tracker_type;
      bfsam_pkg::row_type          adjacency [bfsam_pkg::MAX_NODES];
      logic [bfsam_pkg::CFG_W-1:0] node_count;
      walk_step_type               pending_visits [$];
      int                          errors;

      function new();
         foreach (adjacency[i]) adjacency[i] = '0;
         node_count = bfsam_pkg::CFG_W'(16);
         errors = 0;
      endfunction

      function int unsigned live_nodes();
         return (node_count > bfsam_pkg::MAX_NODES) ? bfsam_pkg::MAX_NODES : node_count;
      endfunction

      function void note_request(bfsam_pkg::req_kind_type kind,
                                 logic [bfsam_pkg::NODE_W-1:0] a,
                                 logic [bfsam_pkg::NODE_W-1:0] b);
         int unsigned                  n;
         bfsam_pkg::row_type           reached;
         logic [bfsam_pkg::NODE_W-1:0] frontier [$];
         logic [bfsam_pkg::NODE_W-1:0] cur;
         walk_step_type                found [$];
         n = live_nodes();
         if (kind == bfsam_pkg::REQ_EDGE) begin
            if (a < n && b < n) begin
               adjacency[a][b] = 1'b1;
               adjacency[b][a] = 1'b1;
            end
            return;
         end
         if (a >= n) begin
            pending_visits.push_back('{node: a, last_flag: 1'b1, bad_flag: 1'b1});
            return;
         end
         reached = '0;
         reached[a] = 1'b1;
         frontier.push_back(a);
         found.push_back('{node: a, last_flag: 1'b0, bad_flag: 1'b0});
         while (frontier.size() != 0) begin
            cur = frontier.pop_front();
            for (int i = 0; i < n; i++) begin
               if (adjacency[cur][i] && !reached[i]) begin
                  reached[i] = 1'b1;
                  frontier.push_back(bfsam_pkg::NODE_W'(i));
                  found.push_back('{node: bfsam_pkg::NODE_W'(i), last_flag: 1'b0,
                                    bad_flag: 1'b0});
               end
            end
         end
         found[found.size()-1].last_flag = 1'b1;
         foreach (found[i]) pending_visits.push_back(found[i]);
      endfunction

      function void check_visit(logic [bfsam_pkg::NODE_W-1:0] node, logic last_flag,
                                logic bad_flag);
         walk_step_type want;
         if (pending_visits.size() == 0) begin
            $error("unexpected result: visited_node %0d last_of_run %0d bad_start %0d",
                   node, last_flag, bad_flag);
            errors++;
            return;
         end
         want = pending_visits.pop_front();
         if (node !== want.node) begin
            $error("visited_node: expected %0d, got %0d", want.node, node);
            errors++;
         end
         if (last_flag !== want.last_flag) begin
            $error("last_of_run: expected %0d, got %0d", want.last_flag, last_flag);
            errors++;
         end
         if (bad_flag !== want.bad_flag) begin
            $error("bad_start: expected %0d, got %0d", want.bad_flag, bad_flag);
            errors++;
         end
      endfunction
   endclass

   logic                         clock;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic                         req_type;
   logic [bfsam_pkg::NODE_W-1:0] req_node_a;
   logic [bfsam_pkg::NODE_W-1:0] req_node_b;
   logic                         rsp_strobe;
   logic [bfsam_pkg::NODE_W-1:0] rsp_visited_node;
   logic                         rsp_last_of_run;
   logic                         rsp_bad_start;
   logic                         csr_valid;
   logic                         csr_ready;
   logic [bfsam_pkg::CFG_W-1:0]  csr_data;

   bfs_walk_tracker_type tracker;
   int                   sender_idle_pct;

   bfs_adjacency_matrix_walk_unit dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_node_a       (req_node_a),
      .req_node_b       (req_node_b),
      .rsp_strobe       (rsp_strobe),
      .rsp_visited_node (rsp_visited_node),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_bad_start    (rsp_bad_start),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         tracker.check_visit(rsp_visited_node, rsp_last_of_run, rsp_bad_start);
      end
   end

   // Called at a falling edge; returns at the falling edge after the transaction.
   task automatic send_request(input bfsam_pkg::req_kind_type kind,
                               input logic [bfsam_pkg::NODE_W-1:0] a,
                               input logic [bfsam_pkg::NODE_W-1:0] b);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start      <= 1'b1;
      req_type   <= kind;
      req_node_a <= a;
      req_node_b <= b;
      @(posedge clock);
      while (busy) @(posedge clock);
      tracker.note_request(kind, a, b);
      @(negedge clock);
   endtask

   // Waits until every predicted result has come and the block has gone idle.
   task automatic settle();
      int waited;
      waited = 0;
      start <= 1'b0;
      while ((tracker.pending_visits.size() != 0 || busy) && waited < 2000) begin
         @(negedge clock);
         waited++;
      end
      // An edge transaction gives no result, so allow it time to land.
      repeat (4) @(negedge clock);
   endtask

   task automatic write_node_count(input logic [bfsam_pkg::CFG_W-1:0] value);
      settle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tracker.node_count = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_random(input int count);
      bfsam_pkg::req_kind_type      kind;
      logic [bfsam_pkg::NODE_W-1:0] a;
      logic [bfsam_pkg::NODE_W-1:0] b;
      int unsigned                  n;
      for (int k = 0; k < count; k++) begin
         n = tracker.live_nodes();
         kind = ($urandom_range(99) < 35) ? bfsam_pkg::REQ_EDGE : bfsam_pkg::REQ_SEARCH;
         // Mostly in-range nodes so the walks grow; the rest exercise rejection.
         if ($urandom_range(99) < 78) begin
            a = bfsam_pkg::NODE_W'($urandom_range(n - 1));
            b = bfsam_pkg::NODE_W'($urandom_range(n - 1));
         end else begin
            a = bfsam_pkg::NODE_W'($urandom_range(15));
            b = bfsam_pkg::NODE_W'($urandom_range(15));
         end
         send_request(kind, a, b);
      end
   endtask

   initial begin
      clock      = 1'b0;
      reset      = 1'b1;
      start      = 1'b0;
      req_type   = bfsam_pkg::REQ_EDGE;
      req_node_a = '0;
      req_node_b = '0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      sender_idle_pct = 0;
      tracker = new();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset node count of sixteen, empty matrix, then a self loop and a small graph.
      send_request(bfsam_pkg::REQ_SEARCH, 4'd0, 4'd0);
      send_request(bfsam_pkg::REQ_EDGE, 4'd3, 4'd3);
      send_request(bfsam_pkg::REQ_SEARCH, 4'd3, 4'd15);
      send_request(bfsam_pkg::REQ_EDGE, 4'd0, 4'd15);
      send_request(bfsam_pkg::REQ_EDGE, 4'd15, 4'd1);
      send_request(bfsam_pkg::REQ_EDGE, 4'd0, 4'd2);
      send_request(bfsam_pkg::REQ_EDGE, 4'd2, 4'd1);
      send_request(bfsam_pkg::REQ_SEARCH, 4'd0, 4'd9);
      send_request(bfsam_pkg::REQ_SEARCH, 4'd15, 4'd0);

      // Edges past the node count are dropped and high start nodes are rejected.
      write_node_count(5'd5);
      send_request(bfsam_pkg::REQ_EDGE, 4'd4, 4'd9);
      send_request(bfsam_pkg::REQ_EDGE, 4'd12, 4'd3);
      send_request(bfsam_pkg::REQ_EDGE, 4'd4, 4'd2);
      send_request(bfsam_pkg::REQ_SEARCH, 4'd9, 4'd0);
      send_request(bfsam_pkg::REQ_SEARCH, 4'd4, 4'd0);
      send_request(bfsam_pkg::REQ_SEARCH, 4'd15, 4'd15);

      write_node_count(5'd0);
      send_request(bfsam_pkg::REQ_EDGE, 4'd0, 4'd1);
      send_request(bfsam_pkg::REQ_SEARCH, 4'd0, 4'd0);

      // Counts above sixteen behave as sixteen.
      write_node_count(5'd31);
      send_request(bfsam_pkg::REQ_SEARCH, 4'd1, 4'd6);

      write_node_count(5'd1);
      send_request(bfsam_pkg::REQ_SEARCH, 4'd0, 4'd0);
      send_request(bfsam_pkg::REQ_EDGE, 4'd0, 4'd0);
      send_request(bfsam_pkg::REQ_SEARCH, 4'd1, 4'd0);

      write_node_count(5'd6);
      sender_idle_pct = 12;
      run_random(70);

      write_node_count(5'd11);
      sender_idle_pct = 72;
      run_random(70);

      write_node_count(5'd16);
      sender_idle_pct = 0;
      run_random(70);

      settle();
      repeat (70) @(negedge clock);
      if (tracker.pending_visits.size() != 0) begin
         $error("%0d expected results never arrived", tracker.pending_visits.size());
         tracker.errors++;
      end
      if (tracker.errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

### bfs_adjacency_matrix_walk_unit.f
+incdir+hdl
hdl/bfsam_pkg.sv
hdl/bfsam_pick.sv
hdl/bfs_adjacency_matrix_walk_unit.sv
bench/bfs_adjacency_matrix_walk_unit_test.sv
